FILE: hw/rtl/mlr_pkg.sv
// ----------------------------------------------------------------------------
// mlr_pkg
// Shared constants and types for the midpoint line rasterizer.
// ----------------------------------------------------------------------------
package mlr_pkg;

  // Default coordinate width in bits.
  localparam int COORD_BITS_DEF = 12;

  // Command kinds.
  localparam logic [1:0] KIND_MOVE = 2'd0;
  localparam logic [1:0] KIND_LINE = 2'd1;
  localparam logic [1:0] KIND_STEP = 2'd2;

  // Slope classes of a walk.
  localparam logic [2:0] SLOPE_VERT     = 3'd0;
  localparam logic [2:0] SLOPE_STEEP_UP = 3'd1;
  localparam logic [2:0] SLOPE_FLAT_UP  = 3'd2;
  localparam logic [2:0] SLOPE_FLAT_DN  = 3'd3;
  localparam logic [2:0] SLOPE_STEEP_DN = 3'd4;

  // Control outcome of a line setup.
  typedef struct packed {
    logic [2:0] slope_class;
    logic       walking;
  } setup_ctrl_t;

endpackage

FILE: hw/rtl/mlr_line_setup.sv
// ----------------------------------------------------------------------------
// mlr_line_setup
// Orders the endpoints of a new line, classifies its slope and computes the
// starting pixel, stop coordinate, extents and initial decision value.
// ----------------------------------------------------------------------------
module mlr_line_setup #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]   cur_x,
  input  logic signed [COORD_BITS-1:0]   cur_y,
  input  logic signed [COORD_BITS-1:0]   end_x,
  input  logic signed [COORD_BITS-1:0]   end_y,
  output logic signed [COORD_BITS-1:0]   start_x,
  output logic signed [COORD_BITS-1:0]   start_y,
  output logic signed [COORD_BITS-1:0]   stop_coord,
  output logic signed [COORD_BITS+3:0]   decision,
  output logic signed [COORD_BITS:0]     delta_x,
  output logic signed [COORD_BITS:0]     delta_y,
  output mlr_pkg::setup_ctrl_t           ctrl
);
  import mlr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 4;

  logic signed [C+1:0]  dx_raw;
  logic signed [C+1:0]  dy_raw;
  logic signed [C+1:0]  nx;
  logic signed [C+1:0]  ny;
  logic signed [C+1:0]  neg_nx;
  logic [2:0]           slope;
  logic                 swap;
  logic signed [C-1:0]  x0, y0, x1, y1;
  logic signed [C:0]    ddx, ddy;
  logic signed [DW-1:0] dx_e, dy_e;

  // Raw extents and their x-normalized form.
  assign dx_raw = {{2{end_x[C-1]}}, end_x} - {{2{cur_x[C-1]}}, cur_x};
  assign dy_raw = {{2{end_y[C-1]}}, end_y} - {{2{cur_y[C-1]}}, cur_y};
  assign nx     = dx_raw[C+1] ? -dx_raw : dx_raw;
  assign ny     = dx_raw[C+1] ? -dy_raw : dy_raw;
  assign neg_nx = -nx;

  // Slope class and whether the endpoints are walked in reverse.
  always_comb begin
    if (dx_raw == '0) begin
      slope = SLOPE_VERT;
      swap  = cur_y > end_y;
    end else if (ny > nx) begin
      slope = SLOPE_STEEP_UP;
      swap  = cur_y > end_y;
    end else if (ny >= 0) begin
      slope = SLOPE_FLAT_UP;
      swap  = cur_x > end_x;
    end else if (ny >= neg_nx) begin
      slope = SLOPE_FLAT_DN;
      swap  = cur_x > end_x;
    end else begin
      slope = SLOPE_STEEP_DN;
      swap  = cur_y < end_y;
    end
  end

  // Ordered endpoints and their extents.
  assign x0  = swap ? end_x : cur_x;
  assign y0  = swap ? end_y : cur_y;
  assign x1  = swap ? cur_x : end_x;
  assign y1  = swap ? cur_y : end_y;
  assign ddx = {x1[C-1], x1} - {x0[C-1], x0};
  assign ddy = {y1[C-1], y1} - {y0[C-1], y0};
  assign dx_e = {{3{ddx[C]}}, ddx};
  assign dy_e = {{3{ddy[C]}}, ddy};

  // Initial decision value and stop coordinate per class.
  always_comb begin
    case (slope)
      SLOPE_VERT: begin
        decision   = '0;
        stop_coord = y1;
      end
      SLOPE_STEEP_UP: begin
        decision   = (dx_e <<< 1) - dy_e;
        stop_coord = y1;
      end
      SLOPE_FLAT_UP: begin
        decision   = dx_e - (dy_e <<< 1);
        stop_coord = x1;
      end
      SLOPE_FLAT_DN: begin
        decision   = -dx_e - (dy_e <<< 1);
        stop_coord = x1;
      end
      default: begin
        decision   = -(dx_e <<< 1) - dy_e;
        stop_coord = y1;
      end
    endcase
  end

  assign start_x = x0;
  assign start_y = y0;
  assign delta_x = ddx;
  assign delta_y = ddy;

  // A walk only starts when the loop coordinate has somewhere to go.
  assign ctrl.slope_class = slope;
  assign ctrl.walking     = (slope inside {SLOPE_FLAT_UP, SLOPE_FLAT_DN}) ?
                            (x0 != x1) : (y0 != y1);

endmodule

FILE: hw/rtl/midpoint_line_rasterizer.sv
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer
// Midpoint line walker driven by move, line and step commands.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid, in_stall, kind, point_x, point_y)
// carries one command word per handshake. A move sets the current point; a
// line starts a walk from the current point to its endpoint and makes the
// endpoint the new current point. Each step word during a walk produces one
// word on the output channel (out_valid, out_stall, pixel_x, pixel_y,
// last_pixel); last_pixel marks the final pixel, and the far endpoint is
// not drawn. Steps while idle and unused kinds produce nothing.
// A step word passes through the input register and its pixel through the
// result register. Throughput is one word per cycle while out_stall is low,
// set by the single add and compare of the decision update per step.
// When the receiver stalls, the pending pixel holds and the command in the
// input register waits; in_stall rises only while that command needs the
// occupied result register. Reset (rst, synchronous) clears the current
// point and the walk state, leaving the block idle with both channels empty.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer #(
  parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   kind,
  input  logic signed [COORD_BITS-1:0] point_x,
  input  logic signed [COORD_BITS-1:0] point_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [COORD_BITS-1:0] pixel_x,
  output logic signed [COORD_BITS-1:0] pixel_y,
  output logic                         last_pixel
);
  import mlr_pkg::*;

  localparam int C  = COORD_BITS;
  localparam int DW = COORD_BITS + 4;

  // Input register.
  logic                 in_reg_valid;
  logic [1:0]           in_kind;
  logic signed [C-1:0]  in_x, in_y;

  // Walk state.
  logic signed [C-1:0]  current_x, current_y;
  logic signed [C-1:0]  walk_x, walk_y;
  logic signed [C-1:0]  stop_coord;
  logic signed [DW-1:0] decision;
  logic signed [C:0]    delta_x, delta_y;
  logic [2:0]           slope_class;
  logic                 walking;

  // Setup results for a line command.
  logic signed [C-1:0]  su_x, su_y, su_stop;
  logic signed [DW-1:0] su_decision;
  logic signed [C:0]    su_dx, su_dy;
  setup_ctrl_t          su_ctrl;

  // Step results.
  logic signed [C-1:0]  walk_x_next, walk_y_next, loop_next;
  logic signed [DW-1:0] decision_next;
  logic signed [DW-1:0] dx2, dy2;
  logic                 step_last;

  logic out_free;
  logic produces;
  logic s2_go;
  logic accept;

  mlr_line_setup #(
    .COORD_BITS (COORD_BITS)
  ) u_setup (
    .cur_x      (current_x),
    .cur_y      (current_y),
    .end_x      (in_x),
    .end_y      (in_y),
    .start_x    (su_x),
    .start_y    (su_y),
    .stop_coord (su_stop),
    .decision   (su_decision),
    .delta_x    (su_dx),
    .delta_y    (su_dy),
    .ctrl       (su_ctrl)
  );

  // Handshake: the input register drains unless its word needs a busy output.
  assign out_free = !out_valid || !out_stall;
  assign produces = (in_kind == KIND_STEP) && walking;
  assign s2_go    = in_reg_valid && (out_free || !produces);
  assign in_stall = in_reg_valid && !s2_go;
  assign accept   = in_valid && !in_stall;

  // Midpoint step along the major axis.
  assign dx2 = {{2{delta_x[C]}}, delta_x, 1'b0};
  assign dy2 = {{2{delta_y[C]}}, delta_y, 1'b0};

  always_comb begin
    walk_x_next   = walk_x;
    walk_y_next   = walk_y;
    decision_next = decision;
    case (slope_class)
      SLOPE_VERT: begin
        walk_y_next = walk_y + 1'b1;
      end
      SLOPE_STEEP_UP: begin
        if (!decision[DW-1]) begin
          walk_x_next   = walk_x + 1'b1;
          decision_next = decision + dx2 - dy2;
        end else begin
          decision_next = decision + dx2;
        end
        walk_y_next = walk_y + 1'b1;
      end
      SLOPE_FLAT_UP: begin
        if (decision[DW-1]) begin
          walk_y_next   = walk_y + 1'b1;
          decision_next = decision + dx2 - dy2;
        end else begin
          decision_next = decision - dy2;
        end
        walk_x_next = walk_x + 1'b1;
      end
      SLOPE_FLAT_DN: begin
        if (decision > 0) begin
          walk_y_next   = walk_y - 1'b1;
          decision_next = decision - dx2 - dy2;
        end else begin
          decision_next = decision - dy2;
        end
        walk_x_next = walk_x + 1'b1;
      end
      default: begin
        if (decision[DW-1]) begin
          walk_x_next   = walk_x + 1'b1;
          decision_next = decision - dx2 - dy2;
        end else begin
          decision_next = decision - dx2;
        end
        walk_y_next = walk_y - 1'b1;
      end
    endcase
  end

  assign loop_next = (slope_class inside {SLOPE_FLAT_UP, SLOPE_FLAT_DN}) ?
                     walk_x_next : walk_y_next;
  assign step_last = loop_next == stop_coord;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (accept) begin
      in_reg_valid <= 1'b1;
    end else if (s2_go) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_kind <= kind;
      in_x    <= point_x;
      in_y    <= point_y;
    end
  end

  // Command execution against the walk state.
  always_ff @(posedge clk) begin
    if (rst) begin
      current_x   <= '0;
      current_y   <= '0;
      walk_x      <= '0;
      walk_y      <= '0;
      stop_coord  <= '0;
      decision    <= '0;
      delta_x     <= '0;
      delta_y     <= '0;
      slope_class <= SLOPE_VERT;
      walking     <= 1'b0;
    end else if (s2_go) begin
      case (in_kind)
        KIND_MOVE: begin
          current_x <= in_x;
          current_y <= in_y;
        end
        KIND_LINE: begin
          walk_x      <= su_x;
          walk_y      <= su_y;
          stop_coord  <= su_stop;
          decision    <= su_decision;
          delta_x     <= su_dx;
          delta_y     <= su_dy;
          slope_class <= su_ctrl.slope_class;
          walking     <= su_ctrl.walking;
          current_x   <= in_x;
          current_y   <= in_y;
        end
        KIND_STEP: begin
          if (walking) begin
            walk_x   <= walk_x_next;
            walk_y   <= walk_y_next;
            decision <= decision_next;
            if (step_last) begin
              walking <= 1'b0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && produces) begin
      out_valid <= 1'b1;
    end else if (out_free) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && produces) begin
      pixel_x    <= walk_x;
      pixel_y    <= walk_y;
      last_pixel <= step_last;
    end
  end

endmodule

FILE: bench/midpoint_line_rasterizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_line_rasterizer_tb
// Self-checking bench for the midpoint line rasterizer. A short directed table
// covers reset, zero-length lines, idle steps, unused kinds, coordinate
// extremes and every slope class. Random move, line and step sequences
// follow. A cycle-free model of the walk predicts every pixel word, and each
// word from the block is compared field by field with the oldest prediction.
// The sender idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module midpoint_line_rasterizer_tb;
  import mlr_pkg::*;

  localparam int CB           = COORD_BITS_DEF;
  localparam int COORD_MIN    = -(1 << (CB - 1));
  localparam int COORD_MAX    = (1 << (CB - 1)) - 1;
  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 20;
  localparam int REPORT_MAX   = 10;

  // Command code that the block ignores.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
    logic                 last;
  } pixel_t;

  typedef struct {
    logic [1:0] op;
    int         x;
    int         y;
    bit         typed;
    bit         has_pix;
    int         px;
    int         py;
    bit         last;
  } plan_row_t;

  typedef enum {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_COMB} flow_t;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_stall;
  logic [1:0]           kind;
  logic signed [CB-1:0] point_x;
  logic signed [CB-1:0] point_y;
  logic                 out_valid;
  logic                 out_stall;
  logic signed [CB-1:0] pixel_x;
  logic signed [CB-1:0] pixel_y;
  logic                 last_pixel;

  midpoint_line_rasterizer #(.COORD_BITS(CB)) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .kind       (kind),
    .point_x    (point_x),
    .point_y    (point_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .last_pixel (last_pixel)
  );

  // Walk state of the line model.
  int         cur_x = 0;
  int         cur_y = 0;
  int         pen_x = 0;
  int         pen_y = 0;
  int         stop_at = 0;
  int         dec = 0;
  int         ext_x = 0;
  int         ext_y = 0;
  logic [2:0] slope = SLOPE_VERT;
  bit         busy = 0;

  pixel_t pending_pixels[$];
  int     mismatches = 0;
  int     words_used = 0;
  int     burst_left = 0;
  int     idle_cycles = 0;
  flow_t  flow_mode = FLOW_FREE;
  int     flow_left = 0;

  // Directed words; typed rows carry an expectation read off by hand.
  plan_row_t plan [24] = '{
    '{KIND_STEP,       0,     0, 1, 0,     0,     0, 0},
    '{KIND_LINE,       0,     0, 1, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 1, 0,     0,     0, 0},
    '{KIND_UNUSED,  2047,    -1, 1, 0,     0,     0, 0},
    '{KIND_MOVE,   -2048, -2048, 1, 0,     0,     0, 0},
    '{KIND_LINE,   -2048,  2047, 1, 0,     0,     0, 0},
    '{KIND_STEP,      -1,    -1, 1, 1, -2048, -2048, 0},
    '{KIND_STEP,    2047,  2047, 1, 1, -2048, -2047, 0},
    '{KIND_MOVE,    2047,  2047, 1, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 1, 1, -2048, -2046, 0},
    '{KIND_LINE,    2047, -2048, 1, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 1, 1,  2047, -2048, 0},
    '{KIND_LINE,    2046, -2047, 1, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 1, 1,  2046, -2047, 1},
    '{KIND_STEP,       0,     0, 1, 0,     0,     0, 0},
    '{KIND_LINE,    2047, -2045, 0, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 0, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 0, 0,     0,     0, 0},
    '{KIND_LINE,    2045, -2047, 0, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 0, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 0, 0,     0,     0, 0},
    '{KIND_LINE,    2044, -2045, 0, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 0, 0,     0,     0, 0},
    '{KIND_STEP,       0,     0, 0, 0,     0,     0, 0}
  };

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one command word to the line model and returns the pixel, if any.
  task automatic rasterize_word(input logic [1:0] op, input int px, input int py,
                                output bit has, output pixel_t pix);
    int  x0, y0, x1, y1, dx, dy, nx, ny, t, along;
    bit  swap;
    has = 0;
    pix = '0;
    case (op)
      KIND_MOVE: begin
        cur_x = px;
        cur_y = py;
      end
      KIND_LINE: begin
        x0 = cur_x; y0 = cur_y; x1 = px; y1 = py;
        dx = x1 - x0; dy = y1 - y0;
        nx = dx; ny = dy;
        if (nx < 0) begin
          nx = -nx;
          ny = -ny;
        end
        // Classify the slope and order the endpoints along the walk.
        if (dx == 0) begin
          slope = SLOPE_VERT; swap = y0 > y1;
        end else if (ny > nx) begin
          slope = SLOPE_STEEP_UP; swap = y0 > y1;
        end else if (ny >= 0) begin
          slope = SLOPE_FLAT_UP; swap = x0 > x1;
        end else if (ny >= -nx) begin
          slope = SLOPE_FLAT_DN; swap = x0 > x1;
        end else begin
          slope = SLOPE_STEEP_DN; swap = y0 < y1;
        end
        if (swap) begin
          t = x0; x0 = x1; x1 = t;
          t = y0; y0 = y1; y1 = t;
        end
        ext_x = x1 - x0;
        ext_y = y1 - y0;
        pen_x = x0;
        pen_y = y0;
        case (slope)
          SLOPE_VERT:     begin dec = 0;                   stop_at = y1; end
          SLOPE_STEEP_UP: begin dec = 2 * ext_x - ext_y;   stop_at = y1; end
          SLOPE_FLAT_UP:  begin dec = ext_x - 2 * ext_y;   stop_at = x1; end
          SLOPE_FLAT_DN:  begin dec = -ext_x - 2 * ext_y;  stop_at = x1; end
          default:        begin dec = -2 * ext_x - ext_y;  stop_at = y1; end
        endcase
        if (slope inside {SLOPE_FLAT_UP, SLOPE_FLAT_DN}) busy = pen_x != stop_at;
        else busy = pen_y != stop_at;
        cur_x = px;
        cur_y = py;
      end
      KIND_STEP: begin
        if (busy) begin
          has = 1;
          pix.x = pen_x[CB-1:0];
          pix.y = pen_y[CB-1:0];
          // Advance along the major axis; the decision picks the minor step.
          case (slope)
            SLOPE_VERT: pen_y++;
            SLOPE_STEEP_UP: begin
              if (dec >= 0) begin
                pen_x++;
                dec += 2 * ext_x - 2 * ext_y;
              end else dec += 2 * ext_x;
              pen_y++;
            end
            SLOPE_FLAT_UP: begin
              if (dec < 0) begin
                pen_y++;
                dec += 2 * ext_x - 2 * ext_y;
              end else dec -= 2 * ext_y;
              pen_x++;
            end
            SLOPE_FLAT_DN: begin
              if (dec > 0) begin
                pen_y--;
                dec -= 2 * ext_x + 2 * ext_y;
              end else dec -= 2 * ext_y;
              pen_x++;
            end
            default: begin
              if (dec < 0) begin
                pen_x++;
                dec -= 2 * ext_x + 2 * ext_y;
              end else dec -= 2 * ext_x;
              pen_y--;
            end
          endcase
          along = (slope inside {SLOPE_FLAT_UP, SLOPE_FLAT_DN}) ? pen_x : pen_y;
          pix.last = along == stop_at;
          if (pix.last) busy = 0;
        end
      end
      default: ;
    endcase
  endtask

  // Presents one word, waits for its handshake, records the expected pixel
  // and then idles the sender at the end of a burst.
  task automatic send_word(input logic [1:0] op, input int x, input int y,
                           input bit typed = 0, input bit typed_has = 0,
                           input pixel_t typed_pix = '0);
    bit     has;
    pixel_t pix;
    int     gap;
    kind     <= op;
    point_x  <= x[CB-1:0];
    point_y  <= y[CB-1:0];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (!(op == KIND_UNUSED || (op == KIND_STEP && !busy))) words_used++;
    rasterize_word(op, x, y, has, pix);
    if (typed) begin
      has = typed_has;
      pix = typed_pix;
    end
    if (has) pending_pixels.push_back(pix);
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 20);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  function automatic int any_coord();
    logic signed [CB-1:0] v;
    v = CB'($urandom());
    return int'(v);
  endfunction

  // A coordinate within a short reach of c, kept inside the coordinate range.
  function automatic int near(int c, int reach);
    int v;
    v = c + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < COORD_MIN) v = COORD_MIN;
    if (v > COORD_MAX) v = COORD_MAX;
    return v;
  endfunction

  // Stimulus: reset, directed table, random sequences, drain.
  initial begin : stimulus
    pixel_t row_pix;
    int     pick;
    int     n;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    kind      <= KIND_MOVE;
    point_x   <= '0;
    point_y   <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      row_pix.x    = plan[i].px[CB-1:0];
      row_pix.y    = plan[i].py[CB-1:0];
      row_pix.last = plan[i].last;
      send_word(plan[i].op, plan[i].x, plan[i].y, plan[i].typed, plan[i].has_pix,
                row_pix);
    end

    words_used = 0;
    while (words_used < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Short line walked to its end, with the odd move, unused word or
        // abandoning line mixed in.
        if ($urandom_range(0, 1) == 1) send_word(KIND_MOVE, any_coord(), any_coord());
        send_word(KIND_LINE, near(cur_x, 12), near(cur_y, 12));
        while (busy) begin
          pick = $urandom_range(0, 99);
          if (pick < 4) send_word(KIND_MOVE, any_coord(), any_coord());
          else if (pick < 7) send_word(KIND_UNUSED, any_coord(), any_coord());
          else if (pick < 9) send_word(KIND_LINE, near(cur_x, 12), near(cur_y, 12));
          else send_word(KIND_STEP, any_coord(), any_coord());
        end
        if ($urandom_range(0, 4) == 0) send_word(KIND_STEP, any_coord(), any_coord());
      end else if (pick < 80) begin
        // Long line across the whole range, left after a few pixels.
        send_word(KIND_MOVE, any_coord(), any_coord());
        send_word(KIND_LINE, any_coord(), any_coord());
        n = $urandom_range(1, 60);
        for (int i = 0; i < n && busy; i++) send_word(KIND_STEP, any_coord(), any_coord());
      end else begin
        // Loose word of any kind.
        send_word(2'($urandom_range(0, 3)), any_coord(), any_coord());
      end
    end

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("midpoint_line_rasterizer_tb OK");
    end else begin
      $display("midpoint_line_rasterizer_tb NOT OK");
    end
    $finish;
  end

  // Pixel check and receiver stall pattern.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      got.x    = pixel_x;
      got.y    = pixel_y;
      got.last = last_pixel;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected pixel word (%0d,%0d,last=%0b)", got.x, got.y, got.last);
      end else begin
        want = pending_pixels.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("pixel mismatch: expected (%0d,%0d,last=%0b) got (%0d,%0d,last=%0b)",
                     want.x, want.y, want.last, got.x, got.y, got.last);
        end
      end
    end
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (flow_left == 0) begin
        flow_mode = flow_t'($urandom_range(0, 3));
        flow_left = $urandom_range(20, 120);
      end else begin
        flow_left--;
      end
      case (flow_mode)
        FLOW_FREE:  out_stall <= 1'b0;
        FLOW_LIGHT: out_stall <= $urandom_range(0, 3) == 0;
        FLOW_HEAVY: out_stall <= $urandom_range(0, 3) != 0;
        default:    out_stall <= (flow_left % 3) == 0;
      endcase
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("midpoint_line_rasterizer_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

FILE: midpoint_line_rasterizer.f
hw/rtl/mlr_pkg.sv
hw/rtl/mlr_line_setup.sv
hw/rtl/midpoint_line_rasterizer.sv
bench/midpoint_line_rasterizer_tb.sv
